/* src/ps2h_pkg.sv */
// ============================================================================
// ps2h_pkg
// Shared types and constants for the PS/2 set-2 scancode to HID key state
// converter.
// ============================================================================
`default_nettype none

package ps2h_pkg;

  localparam int unsigned KEY_SLOTS = 6;
  localparam int unsigned OutSlots  = (KEY_SLOTS < 6) ? KEY_SLOTS : 6;
  localparam int unsigned SlotIdxW  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  localparam logic [7:0] BYTE_REL    = 8'hF0;
  localparam logic [7:0] BYTE_EXT    = 8'hE0;
  localparam logic [7:0] BYTE_PAUSE  = 8'hE1;
  localparam logic [7:0] BYTE_PRTSC  = 8'h12;
  localparam logic [7:0] BYTE_PRTREL = 8'h7C;

  localparam logic [7:0] MOD_LO  = 8'h80;
  localparam logic [7:0] MOD_HI  = 8'h87;
  localparam logic [7:0] CONS_LO = 8'hC0;
  localparam logic [7:0] CONS_HI = 8'hD0;

  localparam logic [2:0] DISC_PRTSC = 3'd3;
  localparam logic [2:0] DISC_PAUSE = 3'd7;

  localparam logic [1:0] REG_EMPTY = 2'd0;
  localparam logic [1:0] REG_PRTSC = 2'd1;
  localparam logic [1:0] REG_PAUSE = 2'd2;

  localparam logic [7:0] RST_EMPTY = 8'd0;
  localparam logic [7:0] RST_PRTSC = 8'd70;
  localparam logic [7:0] RST_PAUSE = 8'd72;

  typedef enum logic [1:0] {
    PFX_IDLE,
    PFX_REL,
    PFX_EXT,
    PFX_EXT_REL
  } pfx_e;

  typedef enum logic [1:0] {
    SRC_TABLE,
    SRC_PRINT,
    SRC_PAUSE
  } src_e;

  typedef struct packed {
    logic valid;
    logic press;
    src_e src;
  } ps2h_evt_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] scan_byte;
    logic       table_select;
    logic [7:0] table_index;
    logic [7:0] table_entry;
  } ps2h_in_t;

  typedef struct packed {
    logic [7:0]  modifier_mask;
    logic [47:0] pressed_slots;
    logic [16:0] consumer_mask;
  } ps2h_out_t;

endpackage

`default_nettype wire

/* src/ps2h_top.sv */
// ============================================================================
// ps2_scancode_to_hid_key_state_top
// PS/2 set-2 scancode bytes in, HID key state reports out. Translation
// tables live in one synchronous memory loaded through the input channel.
// ============================================================================
//   channel | direction | handshake             | beat
//   in      | sink      | in_valid_i/in_ready_o | ps2h_in_t
//   out     | source    | out_valid_o/out_ready_i | ps2h_out_t
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat per cycle in while not stalled: the prefix stage issues the table
// read, the key stage applies the read code and loads the report on a change.
// Reset clears prefix, drop count, masks, slots and the report valid flag;
// the tables are undefined until written. A full report register that is
// not taken stalls the key stage, and the input stalls behind it.
// ============================================================================
`default_nettype none

module ps2_scancode_to_hid_key_state_top (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  ps2h_pkg::ps2h_in_t        in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ps2h_pkg::ps2h_out_t       out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [7:0]           cfg_data_i
);

  logic                 in_fire, s1_adv, s1_valid_q;
  logic                 take, rd_ext;
  ps2h_pkg::ps2h_evt_t  evt0, s1_evt_q;
  logic [7:0]           rdata;
  logic [7:0]           empty_q, prtsc_q, pause_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= ps2h_pkg::RST_EMPTY;
      prtsc_q <= ps2h_pkg::RST_PRTSC;
      pause_q <= ps2h_pkg::RST_PAUSE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ps2h_pkg::REG_EMPTY: empty_q <= cfg_data_i;
        ps2h_pkg::REG_PRTSC: prtsc_q <= cfg_data_i;
        ps2h_pkg::REG_PAUSE: pause_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s1_adv     = !(out_valid_o && !out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign take       = in_fire && !in_data_i.req_type;

  ps2h_prefix u_prefix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_data_i.scan_byte),
    .evt_o  (evt0),
    .ext_o  (rd_ext)
  );

  ps2h_table_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && in_data_i.req_type),
    .waddr_i ({in_data_i.table_select, in_data_i.table_index}),
    .wdata_i (in_data_i.table_entry),
    .re_i    (take),
    .raddr_i ({rd_ext, in_data_i.scan_byte}),
    .rdata_o (rdata)
  );

  // advance key stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_evt_q   <= '0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
      s1_evt_q   <= evt0;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
      s1_evt_q   <= '0;
    end
  end

  ps2h_key_state u_keys (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_valid_q && s1_adv),
    .evt_i        (s1_evt_q),
    .table_code_i (rdata),
    .empty_code_i (empty_q),
    .prtsc_code_i (prtsc_q),
    .pause_code_i (pause_q),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

  a_ready_unless_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !out_ready_i) |-> in_ready_o)
    else $error("input stalled while report path free");

  a_write_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.req_type) |=> !s1_evt_q.valid)
    else $error("table write produced a key event");

  a_report_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q && s1_evt_q.valid))
    else $error("report without a key event");

endmodule

`default_nettype wire

/* src/ps2h_table_ram.sv */
// ============================================================================
// ps2h_table_ram
// Translation memory: standard table in the lower half, extended table in
// the upper half. One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module ps2h_table_ram (
  input  wire logic       clk_i,
  input  wire logic       we_i,
  input  wire logic [8:0] waddr_i,
  input  wire logic [7:0] wdata_i,
  input  wire logic       re_i,
  input  wire logic [8:0] raddr_i,
  output logic      [7:0] rdata_o
);

  logic [7:0] mem [512];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/ps2h_prefix.sv */
// ============================================================================
// ps2h_prefix
// Prefix tracker: follows F0, E0, E0 F0 and E1, counts dropped bytes and
// turns each completed code into a key event and a table select.
// ============================================================================
`default_nettype none

module ps2h_prefix (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                take_i,
  input  wire logic [7:0]          byte_i,
  output ps2h_pkg::ps2h_evt_t      evt_o,
  output logic                     ext_o
);

  ps2h_pkg::pfx_e state_q, state_d;
  logic [2:0]     disc_q, disc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ps2h_pkg::PFX_IDLE;
      disc_q  <= '0;
    end else begin
      state_q <= state_d;
      disc_q  <= disc_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    disc_d      = disc_q;
    evt_o.valid = 1'b0;
    evt_o.press = 1'b1;
    evt_o.src   = ps2h_pkg::SRC_TABLE;
    ext_o       = 1'b0;
    if (take_i) begin
      state_d = ps2h_pkg::PFX_IDLE;
      if (disc_q != '0) begin
        // drop tail byte, keep prefix
        disc_d  = disc_q - 3'd1;
        state_d = state_q;
      end else begin
        case (state_q)
          ps2h_pkg::PFX_REL: begin
            evt_o.valid = 1'b1;
            evt_o.press = 1'b0;
          end
          ps2h_pkg::PFX_EXT: begin
            if (byte_i == ps2h_pkg::BYTE_REL) begin
              state_d = ps2h_pkg::PFX_EXT_REL;
            end else if (byte_i == ps2h_pkg::BYTE_PRTSC) begin
              evt_o.valid = 1'b1;
              evt_o.src   = ps2h_pkg::SRC_PRINT;
            end else begin
              evt_o.valid = 1'b1;
              ext_o       = 1'b1;
            end
          end
          ps2h_pkg::PFX_EXT_REL: begin
            evt_o.valid = 1'b1;
            evt_o.press = 1'b0;
            if (byte_i == ps2h_pkg::BYTE_PRTREL) begin
              disc_d    = ps2h_pkg::DISC_PRTSC;
              evt_o.src = ps2h_pkg::SRC_PRINT;
            end else begin
              ext_o = 1'b1;
            end
          end
          default: begin
            if (byte_i == ps2h_pkg::BYTE_REL) begin
              state_d = ps2h_pkg::PFX_REL;
            end else if (byte_i == ps2h_pkg::BYTE_EXT) begin
              state_d = ps2h_pkg::PFX_EXT;
            end else if (byte_i == ps2h_pkg::BYTE_PAUSE) begin
              disc_d      = ps2h_pkg::DISC_PAUSE;
              evt_o.valid = 1'b1;
              evt_o.src   = ps2h_pkg::SRC_PAUSE;
            end else begin
              evt_o.valid = 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* src/ps2h_key_state.sv */
// ============================================================================
// ps2h_key_state
// Key state update: applies one key event to the modifier mask, consumer
// mask and pressed-key slots, and loads the report register on a change.
// ============================================================================
`default_nettype none

module ps2h_key_state (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  ps2h_pkg::ps2h_evt_t       evt_i,
  input  wire logic [7:0]           table_code_i,
  input  wire logic [7:0]           empty_code_i,
  input  wire logic [7:0]           prtsc_code_i,
  input  wire logic [7:0]           pause_code_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output ps2h_pkg::ps2h_out_t       out_data_o
);

  logic [7:0]  mod_q, mod_d;
  logic [16:0] cons_q, cons_d;
  logic [7:0]  slot_q [ps2h_pkg::KEY_SLOTS];
  logic [7:0]  slot_d [ps2h_pkg::KEY_SLOTS];
  logic        changed;
  logic [7:0]  code;
  logic        match_found, free_found;
  logic [ps2h_pkg::SlotIdxW-1:0] match_idx, free_idx;
  logic        out_valid_q;
  ps2h_pkg::ps2h_out_t out_q, out_d;

  always_comb begin
    case (evt_i.src)
      ps2h_pkg::SRC_PRINT: code = prtsc_code_i;
      ps2h_pkg::SRC_PAUSE: code = pause_code_i;
      default:             code = table_code_i;
    endcase
  end

  always_comb begin
    match_found = 1'b0;
    free_found  = 1'b0;
    match_idx   = '0;
    free_idx    = '0;
    for (int i = 0; i < ps2h_pkg::KEY_SLOTS; i++) begin
      if (slot_q[i] == code) begin
        match_found = 1'b1;
        match_idx   = ps2h_pkg::SlotIdxW'(i);
      end
      if (slot_q[i] == empty_code_i) begin
        free_found = 1'b1;
        free_idx   = ps2h_pkg::SlotIdxW'(i);
      end
    end
  end

  always_comb begin
    mod_d   = mod_q;
    cons_d  = cons_q;
    slot_d  = slot_q;
    changed = 1'b0;
    if (evt_i.valid && code != empty_code_i) begin
      if (code >= ps2h_pkg::MOD_LO && code <= ps2h_pkg::MOD_HI) begin
        if (evt_i.press != mod_q[code[2:0]]) begin
          mod_d[code[2:0]] = evt_i.press;
          changed          = 1'b1;
        end
      end else if (code >= ps2h_pkg::CONS_LO && code <= ps2h_pkg::CONS_HI) begin
        if (evt_i.press != cons_q[code[4:0]]) begin
          cons_d[code[4:0]] = evt_i.press;
          changed           = 1'b1;
        end
      end else if (!code[7]) begin
        if (evt_i.press && !match_found && free_found) begin
          slot_d[free_idx] = code;
          changed          = 1'b1;
        end else if (!evt_i.press && match_found) begin
          slot_d[match_idx] = empty_code_i;
          changed           = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_d.modifier_mask = mod_d;
    out_d.consumer_mask = cons_d;
    out_d.pressed_slots = '0;
    for (int i = 0; i < ps2h_pkg::OutSlots; i++) begin
      out_d.pressed_slots[8*i +: 8] = slot_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= '0;
      cons_q <= '0;
      for (int i = 0; i < ps2h_pkg::KEY_SLOTS; i++) begin
        slot_q[i] <= ps2h_pkg::RST_EMPTY;
      end
    end else if (fire_i) begin
      mod_q  <= mod_d;
      cons_q <= cons_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire_i && changed) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && changed) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
